// ===== hdl/huffdec_pkg.sv =====
// ----------------------------------------------------------------------------
// huffdec_pkg
// Shared types and fixed constants of the preorder-tree Huffman decoder.
// ----------------------------------------------------------------------------
package huffdec_pkg;

    localparam int SYM_W     = 8;   // decoded symbol and leaf literal width
    localparam int LEN_W     = 32;  // output length register width
    localparam int NODE_BASE = 256; // first internal node number
    localparam int LEAF_BITS = 8;   // literal bits after a 0 tree bit
    localparam int BIT_CNT_W = 4;   // holds 0..8

    typedef enum logic [1:0] {
        PH_TREE,
        PH_DECODE,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,   // waiting for the next input item
        ST_BIT,    // one stream bit per cycle unless stalled
        ST_DLV,    // attach a finished subtree to its pending parent
        ST_POP     // load the new top of stack after a pop
    } state_t;

endpackage

// ===== hdl/preorder_tree_huffman_decoder.sv =====
// ----------------------------------------------------------------------------
// preorder_tree_huffman_decoder
// Reads a preorder-serialized Huffman tree from a byte stream, MSB first,
// then decodes codes against it and emits one byte per code.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | dir | handshake
//  ----------+-------------------------------------------+-----+-----------
//  input     | in_byte                                   | in  | in_valid / in_ready
//  output    | symbol, last_symbol, tree_error           | out | out_valid / out_ready
//  config    | cfg_wr_data (output_length)               | in  | cfg_wr_en, no wait
//
//  Steps: an item is taken in ST_IDLE, then its bits are handled in ST_BIT.
//  In the tree, a completed leaf passes through ST_DLV for each parent it fills
//  and through ST_POP for a stack pop; the stack RAM's registered read is why
//  a pop needs ST_POP.
//  Reset: no clearing pass; child tables are written before they are read.
//  Stalls: a result waits while the output register is still full; a decode
//  bit also waits for fresh table data; in_ready is low while an item is handled.
// ----------------------------------------------------------------------------
module preorder_tree_huffman_decoder #(
    parameter int NODE_LIMIT  = 511,
    parameter int STACK_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic [huffdec_pkg::SYM_W-1:0] in_byte,
    input  logic                          in_valid,
    output logic                          in_ready,

    output logic [huffdec_pkg::SYM_W-1:0] symbol,
    output logic                          last_symbol,
    output logic                          tree_error,
    output logic                          out_valid,
    input  logic                          out_ready,

    input  logic                          cfg_wr_en,
    input  logic [huffdec_pkg::LEN_W-1:0] cfg_wr_data
);

    localparam int NW         = $clog2(NODE_LIMIT);        // node value width
    localparam int NNW        = $clog2(NODE_LIMIT + 1);    // next-node counter
    localparam int TABLE_SIZE = NODE_LIMIT - huffdec_pkg::NODE_BASE;
    localparam int TAW        = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int SAW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW         = $clog2(STACK_DEPTH + 1);   // stack level
    localparam int SEW        = NW + 1;                    // {side, node}
    localparam int SW         = huffdec_pkg::SYM_W;
    localparam int CW         = huffdec_pkg::BIT_CNT_W;
    localparam int LENW       = huffdec_pkg::LEN_W;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    huffdec_pkg::state_t state_reg, state_next;
    huffdec_pkg::phase_t phase_reg, phase_next;

    logic [SW-1:0]   byte_reg,     byte_next;
    logic [CW-1:0]   bits_reg,     bits_next;
    logic [NNW-1:0]  nnode_reg,    nnode_next;
    logic [LW-1:0]   level_reg,    level_next;
    logic [SEW-1:0]  top_reg,      top_next;
    logic [SW-1:0]   acc_reg,      acc_next;
    logic [CW-1:0]   leafcnt_reg,  leafcnt_next;
    logic [NW-1:0]   root_reg,     root_next;
    logic [NW-1:0]   walk_reg,     walk_next;
    logic [LENW-1:0] left_reg,     left_next;
    logic [NW-1:0]   dlv_reg,      dlv_next;
    logic            fresh_reg,    fresh_next;
    logic            ovalid_reg,   ovalid_next;
    logic [SW-1:0]   sym_reg,      sym_next;
    logic            last_reg,     last_next;
    logic            err_reg,      err_next;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    logic            zero_we, one_we;
    logic [TAW-1:0]  tw_addr, tr_addr;
    logic [NW-1:0]   tw_data, zero_q, one_q;
    logic            stk_we;
    logic [SAW-1:0]  stk_waddr, stk_raddr;
    logic [SEW-1:0]  stk_wdata, stk_q;

    function automatic logic [TAW-1:0] node_slot(input logic [NW-1:0] node);
        logic [NW-1:0] diff;
        diff = node - NW'(huffdec_pkg::NODE_BASE);
        return diff[TAW-1:0];
    endfunction

    huffdec_ram #(.DW(NW), .DEPTH(TABLE_SIZE), .AW(TAW)) u_zero_tbl (
        .clk   (clk),
        .we    (zero_we),
        .waddr (tw_addr),
        .wdata (tw_data),
        .raddr (tr_addr),
        .rdata (zero_q)
    );

    huffdec_ram #(.DW(NW), .DEPTH(TABLE_SIZE), .AW(TAW)) u_one_tbl (
        .clk   (clk),
        .we    (one_we),
        .waddr (tw_addr),
        .wdata (tw_data),
        .raddr (tr_addr),
        .rdata (one_q)
    );

    huffdec_ram #(.DW(SEW), .DEPTH(STACK_DEPTH), .AW(SAW)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    // ------------------------------------------------------------------
    // shared decisions
    // ------------------------------------------------------------------
    logic            cur_bit, last_bit, slot_free;
    logic            t_leaf_bit, t_leaf_done, t_push_ok, t_dlv;
    logic [SW-1:0]   acc_shift;
    logic [NW-1:0]   d_child;
    logic            d_is_leaf, d_last;
    logic            lvl_zero, top_side, lvl_one;
    logic            f_emit_err;
    huffdec_pkg::phase_t fin_phase;
    logic            stall;
    logic [LW-1:0]   lvl_m1, lvl_m2;

    always_comb
    begin
        cur_bit     = byte_reg[SW-1];
        last_bit    = (bits_reg == CW'(1));
        slot_free   = !ovalid_reg || out_ready;

        t_leaf_bit  = (leafcnt_reg != '0);
        t_leaf_done = (leafcnt_reg == CW'(1));
        acc_shift   = {acc_reg[SW-2:0], cur_bit};
        t_push_ok   = (nnode_reg < NNW'(NODE_LIMIT)) && (level_reg < LW'(STACK_DEPTH));
        t_dlv       = t_leaf_done || (!t_leaf_bit && cur_bit && !t_push_ok);

        d_child     = cur_bit ? one_q : zero_q;
        d_is_leaf   = (d_child < NW'(huffdec_pkg::NODE_BASE));
        d_last      = (left_reg == LENW'(1));

        lvl_zero    = (level_reg == '0);
        lvl_one     = (level_reg == LW'(1));
        top_side    = top_reg[NW];
        lvl_m1      = level_reg - LW'(1);
        lvl_m2      = level_reg - LW'(2);

        // a single-leaf tree yields one error item unless the length is zero
        f_emit_err  = (left_reg != '0) && (dlv_reg < NW'(huffdec_pkg::NODE_BASE));
        if (left_reg == '0 || dlv_reg < NW'(huffdec_pkg::NODE_BASE))
        begin
            fin_phase = huffdec_pkg::PH_DONE;
        end
        else
        begin
            fin_phase = huffdec_pkg::PH_DECODE;
        end

        stall = ((state_reg == huffdec_pkg::ST_BIT) && (phase_reg == huffdec_pkg::PH_DECODE)
                 && (!fresh_reg || (d_is_leaf && !slot_free)))
             || ((state_reg == huffdec_pkg::ST_DLV) && lvl_zero && f_emit_err && !slot_free);
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            huffdec_pkg::ST_IDLE:
            begin
                if (in_valid && phase_reg != huffdec_pkg::PH_DONE)
                begin
                    state_next = huffdec_pkg::ST_BIT;
                end
            end
            huffdec_pkg::ST_BIT:
            begin
                if (phase_reg == huffdec_pkg::PH_TREE)
                begin
                    if (t_dlv)
                        state_next = huffdec_pkg::ST_DLV;
                    else if (last_bit)
                        state_next = huffdec_pkg::ST_IDLE;
                end
                else if (phase_reg == huffdec_pkg::PH_DECODE)
                begin
                    if (!stall && ((d_is_leaf && d_last) || last_bit))
                        state_next = huffdec_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = huffdec_pkg::ST_IDLE;
                end
            end
            huffdec_pkg::ST_DLV:
            begin
                if (!stall)
                begin
                    if (lvl_zero)
                    begin
                        if (bits_reg == '0 || fin_phase == huffdec_pkg::PH_DONE)
                            state_next = huffdec_pkg::ST_IDLE;
                        else
                            state_next = huffdec_pkg::ST_BIT;
                    end
                    else if (!top_side)
                    begin
                        state_next = (bits_reg == '0) ? huffdec_pkg::ST_IDLE
                                                      : huffdec_pkg::ST_BIT;
                    end
                    else if (!lvl_one)
                    begin
                        state_next = huffdec_pkg::ST_POP;
                    end
                end
            end
            huffdec_pkg::ST_POP:
            begin
                state_next = huffdec_pkg::ST_DLV;
            end
            default:
            begin
                state_next = huffdec_pkg::ST_IDLE;
            end
        endcase
        if (cfg_wr_en)
        begin
            state_next = huffdec_pkg::ST_IDLE;
        end
    end

    // ------------------------------------------------------------------
    // datapath and memory controls
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next   = phase_reg;
        byte_next    = byte_reg;
        bits_next    = bits_reg;
        nnode_next   = nnode_reg;
        level_next   = level_reg;
        top_next     = top_reg;
        acc_next     = acc_reg;
        leafcnt_next = leafcnt_reg;
        root_next    = root_reg;
        walk_next    = walk_reg;
        left_next    = left_reg;
        dlv_next     = dlv_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        sym_next     = sym_reg;
        last_next    = last_reg;
        err_next     = err_reg;

        zero_we      = 1'b0;
        one_we       = 1'b0;
        tw_addr      = node_slot(top_reg[NW-1:0]);
        tw_data      = dlv_reg;
        stk_we       = 1'b0;
        stk_waddr    = level_reg[SAW-1:0];
        stk_wdata    = {1'b0, nnode_reg[NW-1:0]};

        unique case (state_reg)
            huffdec_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = in_byte;
                    bits_next = CW'(huffdec_pkg::LEAF_BITS);
                end
            end
            huffdec_pkg::ST_BIT:
            begin
                if (phase_reg == huffdec_pkg::PH_TREE)
                begin
                    byte_next = {byte_reg[SW-2:0], 1'b0};
                    bits_next = bits_reg - CW'(1);
                    if (t_leaf_bit)
                    begin
                        acc_next     = acc_shift;
                        leafcnt_next = leafcnt_reg - CW'(1);
                        if (t_leaf_done)
                            dlv_next = {{(NW-SW){1'b0}}, acc_shift};
                    end
                    else if (!cur_bit)
                    begin
                        leafcnt_next = CW'(huffdec_pkg::LEAF_BITS);
                        acc_next     = '0;
                    end
                    else
                    begin
                        if (nnode_reg < NNW'(NODE_LIMIT))
                            nnode_next = nnode_reg + NNW'(1);
                        if (t_push_ok)
                        begin
                            stk_we     = 1'b1;
                            top_next   = {1'b0, nnode_reg[NW-1:0]};
                            level_next = level_reg + LW'(1);
                        end
                        else
                        begin
                            // node limit or full stack: a 0 leaf, not expanded
                            dlv_next = '0;
                        end
                    end
                end
                else if (phase_reg == huffdec_pkg::PH_DECODE && !stall)
                begin
                    byte_next = {byte_reg[SW-2:0], 1'b0};
                    bits_next = bits_reg - CW'(1);
                    if (d_is_leaf)
                    begin
                        left_next   = left_reg - LENW'(1);
                        ovalid_next = 1'b1;
                        sym_next    = d_child[SW-1:0];
                        last_next   = d_last;
                        err_next    = 1'b0;
                        walk_next   = root_reg;
                        if (d_last)
                            phase_next = huffdec_pkg::PH_DONE;
                    end
                    else
                    begin
                        walk_next = d_child;
                    end
                end
            end
            huffdec_pkg::ST_DLV:
            begin
                if (!stall)
                begin
                    if (lvl_zero)
                    begin
                        root_next  = dlv_reg;
                        walk_next  = dlv_reg;
                        phase_next = fin_phase;
                        if (f_emit_err)
                        begin
                            ovalid_next = 1'b1;
                            sym_next    = '0;
                            last_next   = 1'b1;
                            err_next    = 1'b1;
                            left_next   = '0;
                        end
                    end
                    else if (!top_side)
                    begin
                        zero_we   = 1'b1;
                        top_next  = {1'b1, top_reg[NW-1:0]};
                        stk_we    = 1'b1;
                        stk_waddr = lvl_m1[SAW-1:0];
                        stk_wdata = {1'b1, top_reg[NW-1:0]};
                    end
                    else
                    begin
                        // both children known: the parent is now the subtree
                        one_we     = 1'b1;
                        level_next = lvl_m1;
                        dlv_next   = top_reg[NW-1:0];
                    end
                end
            end
            huffdec_pkg::ST_POP:
            begin
                top_next = stk_q;
            end
            default:
            begin
            end
        endcase

        if (cfg_wr_en)
        begin
            phase_next   = huffdec_pkg::PH_TREE;
            nnode_next   = NNW'(huffdec_pkg::NODE_BASE);
            level_next   = '0;
            acc_next     = '0;
            leafcnt_next = '0;
            root_next    = '0;
            walk_next    = '0;
            left_next    = cfg_wr_data;
        end

        // table read data is marked stale after any write
        fresh_next = !(zero_we || one_we);
    end

    // read address tracks walk_next so the data lines up with walk_reg
    assign tr_addr   = node_slot(walk_next);
    assign stk_raddr = lvl_m2[SAW-1:0];

    // ------------------------------------------------------------------
    // register update
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= huffdec_pkg::ST_IDLE;
            phase_reg   <= huffdec_pkg::PH_TREE;
            bits_reg    <= '0;
            nnode_reg   <= NNW'(huffdec_pkg::NODE_BASE);
            level_reg   <= '0;
            acc_reg     <= '0;
            leafcnt_reg <= '0;
            root_reg    <= '0;
            walk_reg    <= '0;
            left_reg    <= '0;
            fresh_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            bits_reg    <= bits_next;
            nnode_reg   <= nnode_next;
            level_reg   <= level_next;
            acc_reg     <= acc_next;
            leafcnt_reg <= leafcnt_next;
            root_reg    <= root_next;
            walk_reg    <= walk_next;
            left_reg    <= left_next;
            fresh_reg   <= fresh_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        top_reg  <= top_next;
        dlv_reg  <= dlv_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    assign in_ready    = (state_reg == huffdec_pkg::ST_IDLE);
    assign out_valid   = ovalid_reg;
    assign symbol      = sym_reg;
    assign last_symbol = last_reg;
    assign tree_error  = err_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LW'(STACK_DEPTH))
        else $error("stack level past depth");

    a_nnode_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nnode_reg >= NNW'(huffdec_pkg::NODE_BASE)) && (nnode_reg <= NNW'(NODE_LIMIT)))
        else $error("node counter out of range");

    a_decode_root: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == huffdec_pkg::PH_DECODE) |->
            (root_reg >= NW'(huffdec_pkg::NODE_BASE)) &&
            (walk_reg >= NW'(huffdec_pkg::NODE_BASE)))
        else $error("decoding from a leaf");

    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && err_reg) |-> (last_reg && phase_reg == huffdec_pkg::PH_DONE))
        else $error("error item does not end the stream");

    a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == huffdec_pkg::ST_POP) |-> !lvl_zero)
        else $error("pop with empty stack");

endmodule

// ===== hdl/huffdec_ram.sv =====
// ----------------------------------------------------------------------------
// huffdec_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module huffdec_ram #(
    parameter int DW    = 9,
    parameter int DEPTH = 255,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sim/tb_preorder_tree_huffman_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_preorder_tree_huffman_decoder
// Sends byte streams to the decoder: a preorder code tree followed by code
// bits. Expected symbols come from a cycle-free model of the tree build and
// the code walk, and are checked in order against the output item.
// ----------------------------------------------------------------------------
module tb_preorder_tree_huffman_decoder;

    localparam int SYM_W         = huffdec_pkg::SYM_W;
    localparam int LEN_W         = huffdec_pkg::LEN_W;
    localparam int NODE_BASE     = huffdec_pkg::NODE_BASE;
    localparam int LEAF_BITS     = huffdec_pkg::LEAF_BITS;
    localparam int NODE_LIMIT    = 511;
    localparam int STACK_DEPTH   = 256;
    localparam int TABLE_DEPTH   = NODE_LIMIT - NODE_BASE;
    localparam int SETTLE_CYCLES = 700;   // longest pop chain passes ST_DLV and ST_POP per level
    localparam int WATCHDOG_MAX  = 4000;
    localparam int RANDOM_ITEMS  = 160;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             err;
    } symbol_rec_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic [SYM_W-1:0]   in_byte     = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [SYM_W-1:0]   symbol;
    logic               last_symbol;
    logic               tree_error;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]   cfg_wr_data = '0;

    preorder_tree_huffman_decoder #(
        .NODE_LIMIT  (NODE_LIMIT),
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .symbol      (symbol),
        .last_symbol (last_symbol),
        .tree_error  (tree_error),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    huffdec_pkg::phase_t dec_phase;
    logic [8:0]         zero_kid [TABLE_DEPTH];
    logic [8:0]         one_kid  [TABLE_DEPTH];
    logic [9:0]         alloc_node;
    logic [9:0]         open_node [STACK_DEPTH];
    logic               open_side [STACK_DEPTH];   // 1: 0-child already attached
    int                 open_cnt;
    logic [SYM_W-1:0]   lit_acc;
    int                 lit_left;
    logic [8:0]         root_node;
    logic [8:0]         walk_at;
    logic [LEN_W-1:0]   bytes_due;
    symbol_rec_t        symbols_due[$];

    int                 err_cnt = 0;

    function automatic void arm_stream(input logic [LEN_W-1:0] len);
        dec_phase  = huffdec_pkg::PH_TREE;
        alloc_node = 10'(NODE_BASE);
        open_cnt   = 0;
        lit_acc    = '0;
        lit_left   = 0;
        root_node  = '0;
        walk_at    = '0;
        bytes_due  = len;
    endfunction

    // finished subtree v: hang it on the pending parents, popping full ones
    function automatic void attach_subtree(input logic [9:0] v);
        int          top;
        int          slot;
        logic        placed;
        symbol_rec_t rec;
        placed = 1'b0;
        while (!placed && open_cnt > 0)
        begin
            top  = open_cnt - 1;
            slot = (int'(open_node[top]) - NODE_BASE) % TABLE_DEPTH;
            if (!open_side[top])
            begin
                zero_kid[slot] = v[8:0];
                open_side[top] = 1'b1;
                placed         = 1'b1;
            end
            else
            begin
                one_kid[slot] = v[8:0];
                open_cnt      = top;
                v             = open_node[top];
            end
        end
        if (!placed)
        begin
            root_node = v[8:0];
            walk_at   = v[8:0];
            if (bytes_due == 0)
                dec_phase = huffdec_pkg::PH_DONE;
            else if (v < NODE_BASE)
            begin
                rec.sym  = '0;
                rec.last = 1'b1;
                rec.err  = 1'b1;
                symbols_due.push_back(rec);
                bytes_due = 0;
                dec_phase = huffdec_pkg::PH_DONE;
            end
            else
                dec_phase = huffdec_pkg::PH_DECODE;
        end
    endfunction

    function automatic void tree_bit(input logic b);
        logic [9:0] n;
        if (lit_left > 0)
        begin
            lit_acc  = {lit_acc[SYM_W-2:0], b};
            lit_left = lit_left - 1;
            if (lit_left == 0)
                attach_subtree({2'b00, lit_acc});
        end
        else if (!b)
        begin
            lit_left = LEAF_BITS;
            lit_acc  = '0;
        end
        else
        begin
            n = alloc_node;
            if (alloc_node < NODE_LIMIT)
                alloc_node = alloc_node + 10'd1;
            // past the node limit or with a full stack the node is a plain leaf 0
            if (n < NODE_LIMIT && open_cnt < STACK_DEPTH)
            begin
                open_node[open_cnt] = n;
                open_side[open_cnt] = 1'b0;
                open_cnt            = open_cnt + 1;
            end
            else
                attach_subtree('0);
        end
    endfunction

    function automatic void walk_bit(input logic b);
        int          slot;
        logic [8:0]  child;
        symbol_rec_t rec;
        slot  = (int'(walk_at) - NODE_BASE) % TABLE_DEPTH;
        child = b ? one_kid[slot] : zero_kid[slot];
        if (child >= NODE_BASE)
            walk_at = child;
        else
        begin
            bytes_due = bytes_due - 1;
            rec.sym   = child[SYM_W-1:0];
            rec.last  = (bytes_due == 0);
            rec.err   = 1'b0;
            symbols_due.push_back(rec);
            if (bytes_due == 0)
                dec_phase = huffdec_pkg::PH_DONE;
            walk_at = root_node;
        end
    endfunction

    function automatic void predict_symbols(input logic [SYM_W-1:0] b);
        for (int i = SYM_W - 1; i >= 0; i--)
        begin
            if (dec_phase == huffdec_pkg::PH_TREE)
                tree_bit(b[i]);
            else if (dec_phase == huffdec_pkg::PH_DECODE)
                walk_bit(b[i]);
        end
    endfunction

    function automatic void check_symbol();
        symbol_rec_t want;
        if (symbols_due.size() == 0)
        begin
            $error("unexpected item: symbol %0h last %0b tree_error %0b",
                   symbol, last_symbol, tree_error);
            err_cnt++;
        end
        else
        begin
            want = symbols_due.pop_front();
            if (symbol !== want.sym)
            begin
                $error("symbol: expected %0h, got %0h", want.sym, symbol);
                err_cnt++;
            end
            if (last_symbol !== want.last)
            begin
                $error("last_symbol: expected %0b, got %0b", want.last, last_symbol);
                err_cnt++;
            end
            if (tree_error !== want.err)
            begin
                $error("tree_error: expected %0b, got %0b", want.err, tree_error);
                err_cnt++;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------
    logic [SYM_W-1:0]   byte_q[$];
    int                 in_gap_max    = 0;
    int                 out_stall_max = 0;
    int                 in_gap;
    int                 out_wait;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_symbols(in_byte);
            if (!in_valid || in_ready)
            begin
                if (in_gap != 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (byte_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= byte_q.pop_front();
                    in_gap   <= $urandom_range(0, in_gap_max);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Symbol receiver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sink
        int n;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_wait  <= 0;
        end
        else if (out_valid && out_ready)
        begin
            check_symbol();
            n = $urandom_range(0, out_stall_max);
            out_ready <= (n == 0);
            out_wait  <= n;
        end
        else if (out_wait > 1)
            out_wait <= out_wait - 1;
        else
        begin
            out_wait  <= 0;
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any accepted item or register write
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------
    bit  stream_bits[$];
    int  stream_items = 0;

    task automatic write_length(input logic [LEN_W-1:0] len);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        arm_stream(len);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic put_field(input logic [31:0] value, input int nbits);
        for (int i = nbits - 1; i >= 0; i--)
            stream_bits.push_back(value[i]);
    endtask

    // random full tree in preorder; root is internal unless max_internal is 0
    task automatic put_tree(input int max_internal);
        int open_subtrees;
        int made;
        open_subtrees = 1;
        made          = 0;
        while (open_subtrees > 0)
        begin
            if (made < max_internal && (made == 0 || $urandom_range(0, 99) < 45))
            begin
                put_field(1, 1);
                made++;
                open_subtrees++;
            end
            else
            begin
                put_field(0, 1);
                put_field($urandom_range(0, 255), SYM_W);
                open_subtrees--;
            end
        end
    endtask

    // pad to a byte boundary with random bits and queue the bytes
    task automatic send_bits();
        logic [SYM_W-1:0] b;
        while (stream_bits.size() % SYM_W != 0)
            stream_bits.push_back(1'($urandom));
        @(negedge clk);
        while (stream_bits.size() != 0)
        begin
            for (int i = 0; i < SYM_W; i++)
                b = {b[SYM_W-2:0], stream_bits.pop_front()};
            byte_q.push_back(b);
            stream_items++;
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || in_valid || symbols_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [LEN_W-1:0] len;
        int               pick;

        arm_stream('0);
        in_gap_max    = 15;
        out_stall_max = 15;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // zero length: tree is read, nothing comes out
        write_length('0);
        put_field(1, 1);
        put_field(0, 1); put_field(8'h00, SYM_W);
        put_field(0, 1); put_field(8'hFF, SYM_W);
        put_field(8'hA5, SYM_W);
        send_bits();
        settle();

        // single-leaf tree gives one error item, then input is ignored
        write_length(3);
        put_field(0, 1); put_field(8'hAA, SYM_W);
        send_bits();
        byte_q.push_back(8'hFF);
        settle();

        // single leaf with zero length: no error item either
        write_length('0);
        put_field(0, 1); put_field(8'h5A, SYM_W);
        send_bits();
        settle();

        // two leaves at the symbol extremes, length ends at a byte boundary
        in_gap_max    = 0;
        out_stall_max = 0;
        write_length(5);
        put_field(1, 1);
        put_field(0, 1); put_field(8'h00, SYM_W);
        put_field(0, 1); put_field(8'hFF, SYM_W);
        put_field(5'b01011, 5);
        send_bits();
        byte_q.push_back(8'h00);
        settle();

        // maximum length never finishes; the next write re-arms
        in_gap_max    = 15;
        out_stall_max = 15;
        write_length('1);
        put_field(1, 1);
        put_field(0, 1); put_field(8'h81, SYM_W);
        put_field(1, 1);
        put_field(0, 1); put_field(8'h7E, SYM_W);
        put_field(0, 1); put_field(8'h3C, SYM_W);
        put_field(8'h00, SYM_W);
        put_field(8'hFF, SYM_W);
        put_field(8'hA5, SYM_W);
        send_bits();
        settle();

        write_length(1);
        put_field(1, 1);
        put_field(0, 1); put_field(8'h01, SYM_W);
        put_field(0, 1); put_field(8'h80, SYM_W);
        put_field(8'h40, SYM_W);
        send_bits();
        settle();

        // node limit: all-ones stream allocates every node, then turns
        // further ones into leaf 0 until the tree closes
        in_gap_max    = 3;
        out_stall_max = 3;
        write_length(20);
        repeat (64) put_field(8'hFF, SYM_W);
        put_field(8'hFF, SYM_W);
        put_field(8'hFF, SYM_W);
        put_field(8'h00, SYM_W);
        put_field(8'hFF, SYM_W);
        put_field(8'hFF, SYM_W);
        send_bits();
        settle();

        stream_items = 0;
        while (stream_items < RANDOM_ITEMS)
        begin
            in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 15;
            out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len = '0;
            else if (pick < 10)
                len = '1;
            else if (pick < 15)
                len = $urandom;
            else
                len = $urandom_range(1, 24);
            write_length(len);
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 6)) put_field($urandom_range(0, 255), SYM_W);
            end
            else
            begin
                put_tree(($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                     : $urandom_range(0, 12));
                repeat ($urandom_range(1, 8)) put_field($urandom_range(0, 255), SYM_W);
            end
            send_bits();
            repeat ($urandom_range(0, 2)) byte_q.push_back(8'($urandom));
            settle();
        end

        if (symbols_due.size() != 0)
        begin
            $error("%0d expected symbols never arrived", symbols_due.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
